FILE: hdl/e2q_pkg.sv
// Package for the Euler angle to quaternion block: payload types, CORDIC constants.
// Depends on nothing; used by every module in hdl.
package e2q_pkg;

  localparam int unsigned AngleWidth   = 16;
  localparam int unsigned CordicStages = 24;
  localparam int unsigned CordicWidth  = 34;
  localparam logic signed [CordicWidth-1:0] CordicGain = 34'sd652032874;

  typedef struct packed {
    logic signed [AngleWidth-1:0] heading_angle;
    logic signed [AngleWidth-1:0] pitch_angle;
    logic signed [AngleWidth-1:0] bank_angle;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } out_beat_t;

  // Cosine and sine of the three half angles, 17-bit Q1.15.
  typedef struct packed {
    logic signed [16:0] ch;
    logic signed [16:0] sh;
    logic signed [16:0] cp;
    logic signed [16:0] sp;
    logic signed [16:0] cb;
    logic signed [16:0] sb;
  } trig_t;

  function automatic logic signed [CordicWidth-1:0] atan_lut(input logic [4:0] idx);
    logic signed [CordicWidth-1:0] r;
    r = '0;
    unique case (idx)
      5'd0:  r = 34'sh020000000;
      5'd1:  r = 34'sh012E4051E;
      5'd2:  r = 34'sh009FB385B;
      5'd3:  r = 34'sh0051111D4;
      5'd4:  r = 34'sh0028B0D43;
      5'd5:  r = 34'sh00145D7E1;
      5'd6:  r = 34'sh000A2F61E;
      5'd7:  r = 34'sh000517C55;
      5'd8:  r = 34'sh00028BE53;
      5'd9:  r = 34'sh000145F2F;
      5'd10: r = 34'sh0000A2F98;
      5'd11: r = 34'sh0000517CC;
      5'd12: r = 34'sh000028BE6;
      5'd13: r = 34'sh0000145F3;
      5'd14: r = 34'sh00000A2FA;
      5'd15: r = 34'sh00000517D;
      5'd16: r = 34'sh0000028BE;
      5'd17: r = 34'sh00000145F;
      5'd18: r = 34'sh000000A30;
      5'd19: r = 34'sh000000518;
      5'd20: r = 34'sh00000028C;
      5'd21: r = 34'sh000000146;
      5'd22: r = 34'sh0000000A3;
      5'd23: r = 34'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/e2q_cordic.sv
// Pipelined rotation-mode CORDIC: one stage per register, cosine and sine of a half angle.
// Depends on e2q_pkg.
module e2q_cordic (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic signed [31:0]                       angle_i,
  output logic signed [16:0]                       cos_o,
  output logic signed [16:0]                       sin_o
);
  localparam int unsigned N = e2q_pkg::CordicStages;
  localparam int unsigned W = e2q_pkg::CordicWidth;

  logic signed [W-1:0] x_q [N];
  logic signed [W-1:0] y_q [N];
  logic signed [W-1:0] z_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [W-1:0] x_s, y_s, z_s;
    logic signed [W-1:0] x_d, y_d, z_d;
    if (i == 0) begin : g_first
      assign x_s = e2q_pkg::CordicGain;
      assign y_s = '0;
      assign z_s = W'(angle_i);
    end else begin : g_next
      assign x_s = x_q[i-1];
      assign y_s = y_q[i-1];
      assign z_s = z_q[i-1];
    end
    always_comb begin
      if (!z_s[W-1]) begin
        x_d = x_s - (y_s >>> i);
        y_d = y_s + (x_s >>> i);
        z_d = z_s - e2q_pkg::atan_lut(5'(i));
      end else begin
        x_d = x_s + (y_s >>> i);
        y_d = y_s - (x_s >>> i);
        z_d = z_s + e2q_pkg::atan_lut(5'(i));
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
      end
    end
  end

  // Round Q2.30 to Q1.15 and clamp to [-1, +1].
  function automatic logic signed [16:0] to_q15(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    r = (v + W'(1 << 14)) >>> 15;
    if (r > W'(32768)) return 17'sd32768;
    if (r < -W'(32768)) return -17'sd32768;
    return r[16:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= to_q15(x_q[N-1]);
      sin_o <= to_q15(y_q[N-1]);
    end
  end
endmodule

FILE: hdl/e2q_combine.sv
// Triple-product combiner: two multiply stages, then sum, round and saturate.
// Depends on e2q_pkg.
module e2q_combine (
  input  logic                clk_i,
  input  logic                en_i,
  input  e2q_pkg::trig_t      trig_i,
  output e2q_pkg::out_beat_t  quat_o
);
  // Stage 1: pairwise products (Q2.30, 34 bits).
  logic signed [33:0] chcp_q, shsp_q, chsp_q, shcp_q;
  logic signed [16:0] cb_q, sb_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chcp_q <= trig_i.ch * trig_i.cp;
      shsp_q <= trig_i.sh * trig_i.sp;
      chsp_q <= trig_i.ch * trig_i.sp;
      shcp_q <= trig_i.sh * trig_i.cp;
      cb_q   <= trig_i.cb;
      sb_q   <= trig_i.sb;
    end
  end

  // Stage 2: triple products (Q3.45, 51 bits).
  logic signed [50:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q, p6_q, p7_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= chcp_q * cb_q;
      p1_q <= shsp_q * sb_q;
      p2_q <= chsp_q * cb_q;
      p3_q <= shcp_q * sb_q;
      p4_q <= shcp_q * cb_q;
      p5_q <= chsp_q * sb_q;
      p6_q <= chcp_q * sb_q;
      p7_q <= shsp_q * cb_q;
    end
  end

  function automatic logic signed [15:0] sat(input logic signed [51:0] s);
    logic signed [51:0] r;
    r = (s + 52'sd536870912) >>> 30;
    if (r > 52'sd32767) return 16'sd32767;
    if (r < -52'sd32768) return -16'sd32768;
    return r[15:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quat_o.quat_w <= sat(52'(p0_q) + 52'(p1_q));
      quat_o.quat_x <= sat(52'(p2_q) + 52'(p3_q));
      quat_o.quat_y <= sat(52'(p4_q) - 52'(p5_q));
      quat_o.quat_z <= sat(52'(p6_q) - 52'(p7_q));
    end
  end
endmodule

FILE: hdl/euler_to_quaternion_top.sv
// Euler heading/pitch/bank to Q1.15 quaternion, top level.
// Uses the valid/stall channels on both sides. The path from an accepted input
// beat to the output register holds 24 CORDIC stages, one rounding stage, two
// multiply stages and one sum and saturate stage. One beat enters per cycle
// while the receiver does not stall the output; throughput is one beat per
// clock, set by the fully pipelined CORDIC and multiplier chain.
// The whole pipeline advances together. When the receiver stalls while the
// output holds a beat, every stage freezes and the input is stalled too, so
// nothing is lost or repeated. Empty stages do not stall the input, but gaps
// between beats travel through the pipeline as they are and are not closed up.
// Reset clears all valid bits; data registers are not reset. The block has no
// configuration and no state beyond the pipeline.
// Depends on e2q_pkg, e2q_cordic and e2q_combine.
module euler_to_quaternion_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  e2q_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output e2q_pkg::out_beat_t out_data_o
);
  localparam int unsigned Depth = e2q_pkg::CordicStages + 4;
  localparam int unsigned Aw    = e2q_pkg::AngleWidth;

  logic [Depth-1:0] vld_q;
  logic             en;

  assign en          = !(vld_q[Depth-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // Half angle in a 32-bit turn: place at the top, arithmetic shift right.
  function automatic logic signed [31:0] half(input logic signed [Aw-1:0] a);
    logic signed [31:0] p;
    p = 32'(a) << (32 - Aw);
    return p >>> 1;
  endfunction

  e2q_pkg::trig_t trig;

  e2q_cordic u_head (.clk_i, .en_i(en), .angle_i(half(in_data_i.heading_angle)),
                     .cos_o(trig.ch), .sin_o(trig.sh));
  e2q_cordic u_pitch(.clk_i, .en_i(en), .angle_i(half(in_data_i.pitch_angle)),
                     .cos_o(trig.cp), .sin_o(trig.sp));
  e2q_cordic u_bank (.clk_i, .en_i(en), .angle_i(half(in_data_i.bank_angle)),
                     .cos_o(trig.cb), .sin_o(trig.sb));

  e2q_combine u_comb (.clk_i, .en_i(en), .trig_i(trig), .quat_o(out_data_o));

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted beat lost at entry");
endmodule
